@@ hdl/pct_pkg.sv @@
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the pump cycle timer
// Action classes, run modes, status codes, register indexes, queue entry.
// ----------------------------------------------------------------------------
package pct_pkg;

	localparam int TIME_W      = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int OFFS_W      = 23;

	localparam logic [CFG_INDEX_W-1:0] REG_WORK_SECONDS       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_MINUTES       = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCED_RUN_SECONDS = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELAY_HIGH_LEVEL   = 8'd3;

	localparam logic [TIME_W-1:0] MS_PER_SECOND = 32'd1000;
	localparam logic [TIME_W-1:0] MS_PER_MINUTE = 32'd60000;

	typedef enum logic [2:0] {
		ACT_TICK         = 3'd0,
		ACT_START_NORMAL = 3'd1,
		ACT_START_FORCED = 3'd2,
		ACT_START_TIMED  = 3'd3,
		ACT_STOP         = 3'd4,
		ACT_SET_OFFSET   = 3'd5,
		ACT_NOP          = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_FORCED = 2'd1,
		MODE_TIMED  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DISABLED = 2'd0,
		STAT_WORKING  = 2'd1,
		STAT_WAITING  = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] work_ms;
		logic [TIME_W-1:0] wait_ms;
		logic [TIME_W-1:0] forced_ms;
		logic              relay_high;
		logic              auto_on;
	} cfg_t;

	typedef struct packed {
		action_t           act;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] offs_ms;
	} entry_t;

endpackage

@@ hdl/pct_if.sv @@
// ----------------------------------------------------------------------------
// pct_if: channel interfaces of the pump cycle timer
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface pct_item_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          action;
	logic [pct_pkg::TIME_W-1:0]          now_ms;
	logic signed [pct_pkg::OFFS_W-1:0]   offset_seconds;

	modport source (output valid, action, now_ms, offset_seconds, input ready);
	modport sink (input valid, action, now_ms, offset_seconds, output ready);
endinterface

interface pct_result_if;
	logic                       valid;
	logic                       ready;
	logic                       relay_level;
	logic                       working;
	logic [1:0]                 run_mode;
	logic [1:0]                 status;
	logic                       stopped_event;
	logic [pct_pkg::TIME_W-1:0] shown_time_ms;

	modport source (output valid, relay_level, working, run_mode, status, stopped_event,
		shown_time_ms, input ready);
	modport sink (input valid, relay_level, working, run_mode, status, stopped_event,
		shown_time_ms, output ready);
endinterface

interface pct_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pct_pkg::CFG_INDEX_W-1:0] index;
	logic [pct_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/pct_cfg.sv @@
// ----------------------------------------------------------------------------
// pct_cfg: configuration registers
// Holds the periods already scaled to milliseconds and the relay polarity.
// ----------------------------------------------------------------------------
module pct_cfg (
	input  logic            clk,
	input  logic            arst_n,
	pct_cfg_if.sink         cfg,
	output pct_pkg::cfg_t   cfg_o
);

	logic [pct_pkg::TIME_W-1:0] work_ms_q;
	logic [pct_pkg::TIME_W-1:0] wait_ms_q;
	logic [pct_pkg::TIME_W-1:0] forced_ms_q;
	logic                       relay_high_q;
	logic [pct_pkg::TIME_W-1:0] data_ext;

	assign cfg.ready = 1'b1;
	assign data_ext  = {{(pct_pkg::TIME_W - pct_pkg::CFG_DATA_W){1'b0}}, cfg.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_ms_q    <= '0;
			wait_ms_q    <= '0;
			forced_ms_q  <= '0;
			relay_high_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pct_pkg::REG_WORK_SECONDS:       work_ms_q   <= data_ext * pct_pkg::MS_PER_SECOND;
				pct_pkg::REG_WAIT_MINUTES:       wait_ms_q   <= data_ext * pct_pkg::MS_PER_MINUTE;
				pct_pkg::REG_FORCED_RUN_SECONDS: forced_ms_q <= data_ext * pct_pkg::MS_PER_SECOND;
				pct_pkg::REG_RELAY_HIGH_LEVEL:   relay_high_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// scaled periods are zero exactly when the written value is zero
	always_comb begin
		cfg_o.work_ms    = work_ms_q;
		cfg_o.wait_ms    = wait_ms_q;
		cfg_o.forced_ms  = forced_ms_q;
		cfg_o.relay_high = relay_high_q;
		cfg_o.auto_on    = (work_ms_q != '0) && (wait_ms_q != '0);
	end

endmodule

@@ hdl/pct_front.sv @@
// ----------------------------------------------------------------------------
// pct_front: input front end
// Classifies the action code and scales the offset to milliseconds.
// ----------------------------------------------------------------------------
module pct_front (
	pct_item_if.sink          item,
	input  logic              q_ready,
	output logic              q_valid,
	output pct_pkg::entry_t   q_entry
);

	logic [pct_pkg::TIME_W-1:0] offs_ext;

	assign item.ready = q_ready;
	assign q_valid    = item.valid;
	assign offs_ext   = {{(pct_pkg::TIME_W - pct_pkg::OFFS_W){item.offset_seconds[pct_pkg::OFFS_W-1]}},
		item.offset_seconds};

	always_comb begin
		q_entry.now_ms  = item.now_ms;
		q_entry.offs_ms = offs_ext * pct_pkg::MS_PER_SECOND;
		unique case (item.action)
			pct_pkg::ACT_TICK:         q_entry.act = pct_pkg::ACT_TICK;
			pct_pkg::ACT_START_NORMAL: q_entry.act = pct_pkg::ACT_START_NORMAL;
			pct_pkg::ACT_START_FORCED: q_entry.act = pct_pkg::ACT_START_FORCED;
			pct_pkg::ACT_START_TIMED:  q_entry.act = pct_pkg::ACT_START_TIMED;
			pct_pkg::ACT_STOP:         q_entry.act = pct_pkg::ACT_STOP;
			pct_pkg::ACT_SET_OFFSET:   q_entry.act = pct_pkg::ACT_SET_OFFSET;
			default:                   q_entry.act = pct_pkg::ACT_NOP;
		endcase
	end

endmodule

@@ hdl/pct_queue.sv @@
// ----------------------------------------------------------------------------
// pct_queue: small queue between front and back end
// Register-based first-in first-out buffer with head read.
// ----------------------------------------------------------------------------
module pct_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/pct_back.sv @@
// ----------------------------------------------------------------------------
// pct_back: timer back end
// Updates the run state per beat, then formats status and shown time.
// ----------------------------------------------------------------------------
module pct_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pct_pkg::cfg_t    cfg_i,
	input  logic             q_valid,
	output logic             q_ready,
	input  pct_pkg::entry_t  q_entry,
	pct_result_if.source     result
);

	localparam int TW = pct_pkg::TIME_W;

	logic               running_q;
	pct_pkg::mode_t     mode_q;
	logic [TW-1:0]      start_q;
	logic [TW-1:0]      stop_q;
	logic [TW-1:0]      offset_q;

	logic               running_d;
	pct_pkg::mode_t     mode_d;
	logic [TW-1:0]      start_d;
	logic [TW-1:0]      stop_d;
	logic [TW-1:0]      offset_d;
	logic [TW-1:0]      cur_new;
	logic               stopped_d;

	logic [TW-1:0]      cur;
	logic [TW-1:0]      cur_offs;
	logic [TW-1:0]      run_period;
	logic               tick_start;
	logic               tick_stop;

	logic               valid_s1;
	logic               running_s1;
	pct_pkg::mode_t     mode_s1;
	logic [TW-1:0]      base_s1;
	logic [TW-1:0]      cur_s1;
	logic               stopped_s1;

	logic [TW-1:0]      period;
	logic [TW-1:0]      fin;
	logic [TW-1:0]      shown;
	pct_pkg::status_t   status;

	logic               out_free;
	logic               s1_free;
	logic               pop;

	assign out_free = !result.valid || result.ready;
	assign s1_free  = !valid_s1 || out_free;
	assign q_ready  = s1_free;
	assign pop      = q_valid && s1_free;

	assign cur        = q_entry.now_ms + offset_q;
	assign cur_offs   = q_entry.now_ms + q_entry.offs_ms;
	assign run_period = (mode_q == pct_pkg::MODE_TIMED) ? cfg_i.forced_ms : cfg_i.work_ms;
	assign tick_start = cfg_i.auto_on && !running_q && ((cur - stop_q) >= cfg_i.wait_ms);
	assign tick_stop  = running_q && ((cur - start_q) >= run_period)
		&& (mode_q != pct_pkg::MODE_FORCED);

	always_comb begin
		running_d = running_q;
		mode_d    = mode_q;
		start_d   = start_q;
		stop_d    = stop_q;
		offset_d  = offset_q;
		cur_new   = cur;
		stopped_d = 1'b0;
		unique case (q_entry.act) inside
			pct_pkg::ACT_TICK: begin
				if (tick_start) begin
					running_d = 1'b1;
					offset_d  = '0;
					start_d   = q_entry.now_ms;
					cur_new   = q_entry.now_ms;
				end else if (tick_stop) begin
					running_d = 1'b0;
					stop_d    = cur;
					mode_d    = pct_pkg::MODE_NORMAL;
					stopped_d = 1'b1;
				end
			end
			pct_pkg::ACT_START_NORMAL, pct_pkg::ACT_START_FORCED,
			pct_pkg::ACT_START_TIMED: begin
				running_d = 1'b1;
				offset_d  = '0;
				start_d   = q_entry.now_ms;
				cur_new   = q_entry.now_ms;
				if (q_entry.act == pct_pkg::ACT_START_FORCED) begin
					mode_d = pct_pkg::MODE_FORCED;
				end else if (q_entry.act == pct_pkg::ACT_START_TIMED) begin
					mode_d = pct_pkg::MODE_TIMED;
				end else begin
					mode_d = pct_pkg::MODE_NORMAL;
				end
			end
			pct_pkg::ACT_STOP: begin
				running_d = 1'b0;
				stop_d    = cur;
				mode_d    = pct_pkg::MODE_NORMAL;
				stopped_d = 1'b1;
			end
			pct_pkg::ACT_SET_OFFSET: begin
				offset_d = q_entry.offs_ms;
				cur_new  = cur_offs;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			mode_q    <= pct_pkg::MODE_NORMAL;
			start_q   <= '0;
			stop_q    <= '0;
			offset_q  <= '0;
		end else if (pop) begin
			running_q <= running_d;
			mode_q    <= mode_d;
			start_q   <= start_d;
			stop_q    <= stop_d;
			offset_q  <= offset_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			running_s1 <= running_d;
			mode_s1    <= mode_d;
			base_s1    <= running_d ? start_d : stop_d;
			cur_s1     <= cur_new;
			stopped_s1 <= stopped_d;
		end
	end

	// phase length and shown time (remaining, or elapsed in forced mode) from the updated state
	always_comb begin
		if (mode_s1 == pct_pkg::MODE_TIMED) begin
			period = cfg_i.forced_ms;
		end else if (running_s1) begin
			period = cfg_i.work_ms;
		end else begin
			period = cfg_i.wait_ms;
		end
		fin = base_s1 + period;
		if (!cfg_i.auto_on && (mode_s1 == pct_pkg::MODE_NORMAL)) begin
			status = pct_pkg::STAT_DISABLED;
			shown  = '0;
		end else begin
			status = running_s1 ? pct_pkg::STAT_WORKING : pct_pkg::STAT_WAITING;
			if (mode_s1 == pct_pkg::MODE_FORCED) begin
				shown = cur_s1 - base_s1;
			end else begin
				shown = (cur_s1 < fin) ? (fin - cur_s1) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (out_free) begin
			result.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result.relay_level   <= running_s1 ^ cfg_i.relay_high;
			result.working       <= running_s1;
			result.run_mode      <= mode_s1;
			result.status        <= status;
			result.stopped_event <= stopped_s1;
			result.shown_time_ms <= shown;
		end
	end

endmodule

@@ hdl/pump_cycle_timer_top.sv @@
// ----------------------------------------------------------------------------
// pump_cycle_timer_top: cyclic relay timer for a pump
// Path: an input beat passes the queue, then the stage s1 registers, then the result register.
// Throughput: one item per cycle unless the result side stalls; the run state update is combinational.
// Queue of QUEUE_DEPTH entries lets front and back end stall independently.
// Reset: asynchronous, active low; clears run state, offset, stamps and config.
// ----------------------------------------------------------------------------
module pump_cycle_timer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	pct_item_if.sink      item,
	pct_result_if.source  result,
	pct_cfg_if.sink       cfg
);

	pct_pkg::cfg_t   cfg_s;
	pct_pkg::entry_t front_entry;
	pct_pkg::entry_t head_entry;
	logic            front_valid;
	logic            front_ready;
	logic            head_valid;
	logic            head_ready;

	pct_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_s)
	);

	pct_front u_front (
		.item    (item),
		.q_ready (front_ready),
		.q_valid (front_valid),
		.q_entry (front_entry)
	);

	pct_queue #(
		.W     ($bits(pct_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_entry),
		.rd_valid (head_valid),
		.rd_ready (head_ready),
		.rd_data  (head_entry)
	);

	pct_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_i   (cfg_s),
		.q_valid (head_valid),
		.q_ready (head_ready),
		.q_entry (head_entry),
		.result  (result)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the pump cycle timer
// Directed beats cover every action, the field extremes and the corner cases
// of the timer. Random phases then run tick-heavy traffic under several
// register settings. Each result beat is checked field by field against a
// timer predictor kept in step with every accepted item beat.
// ----------------------------------------------------------------------------
module tb;
	import pct_pkg::*;

	localparam logic [2:0] ACT_RESERVED    = 3'd7;
	localparam int         CYCLE_LIMIT     = 500000;
	localparam int         BEATS_PER_PHASE = 300;

	typedef struct packed {
		logic              relay_level;
		logic              working;
		mode_t             run_mode;
		status_t           status;
		logic              stopped_event;
		logic [TIME_W-1:0] shown_time_ms;
	} pump_view_t;

	logic clk;
	logic arst_n;

	pct_item_if   item_ch ();
	pct_result_if result_ch ();
	pct_cfg_if    cfg_ch ();

	pump_cycle_timer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// timer predictor state
	logic [15:0]       cfg_work_s;
	logic [15:0]       cfg_wait_min;
	logic [15:0]       cfg_forced_s;
	logic              cfg_relay_hi;
	logic              p_running;
	mode_t             p_mode;
	logic [TIME_W-1:0] p_started_at;
	logic [TIME_W-1:0] p_stopped_at;
	logic [TIME_W-1:0] p_offset_ms;

	pump_view_t        pending_views[$];
	int                mismatches  = 0;
	int                cycle_count = 0;
	int                sink_hold   = 0;
	bit                sender_idle = 1'b0;
	bit                sink_idle   = 1'b0;
	logic [TIME_W-1:0] sim_ms;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pump_cycle_timer_top verification failed");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] phase_ms();
		if (p_mode == MODE_TIMED) return 32'(cfg_forced_s) * MS_PER_SECOND;
		if (p_running) return 32'(cfg_work_s) * MS_PER_SECOND;
		return 32'(cfg_wait_min) * MS_PER_MINUTE;
	endfunction

	function automatic void start_pump(logic [TIME_W-1:0] now);
		p_running    = 1'b1;
		p_offset_ms  = '0;
		p_started_at = now;
	endfunction

	function automatic void stop_pump(logic [TIME_W-1:0] cur);
		p_running    = 1'b0;
		p_stopped_at = cur;
		p_mode       = MODE_NORMAL;
	endfunction

	function automatic pump_view_t next_pump_view(logic [2:0] act, logic [TIME_W-1:0] now,
		logic [OFFS_W-1:0] offs);
		pump_view_t        v;
		logic              auto_en;
		logic [TIME_W-1:0] cur;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] idle_ms;
		logic [TIME_W-1:0] run_ms;
		v = '0;
		auto_en = (cfg_work_s != 16'd0) && (cfg_wait_min != 16'd0);
		cur = now + p_offset_ms;
		idle_ms = cur - p_stopped_at;
		run_ms = cur - p_started_at;
		case (act)
			ACT_TICK: begin
				if (auto_en && !p_running && idle_ms >= 32'(cfg_wait_min) * MS_PER_MINUTE) begin
					start_pump(now);
				end else if (p_running && run_ms >= phase_ms() && p_mode != MODE_FORCED) begin
					stop_pump(cur);
					v.stopped_event = 1'b1;
				end
			end
			ACT_START_NORMAL: begin
				p_mode = MODE_NORMAL;
				start_pump(now);
			end
			ACT_START_FORCED: begin
				p_mode = MODE_FORCED;
				start_pump(now);
			end
			ACT_START_TIMED: begin
				p_mode = MODE_TIMED;
				start_pump(now);
			end
			ACT_STOP: begin
				stop_pump(cur);
				v.stopped_event = 1'b1;
			end
			ACT_SET_OFFSET: p_offset_ms = {{(TIME_W-OFFS_W){offs[OFFS_W-1]}}, offs} * MS_PER_SECOND;
			default: ;
		endcase
		cur = now + p_offset_ms;
		if (!auto_en && p_mode == MODE_NORMAL) begin
			v.status = STAT_DISABLED;
		end else begin
			base = p_running ? p_started_at : p_stopped_at;
			v.status = p_running ? STAT_WORKING : STAT_WAITING;
			if (p_mode == MODE_FORCED) begin
				v.shown_time_ms = cur - base;
			end else begin
				fin = base + phase_ms();
				v.shown_time_ms = (cur < fin) ? fin - cur : '0;
			end
		end
		v.relay_level = p_running ^ cfg_relay_hi;
		v.working     = p_running;
		v.run_mode    = p_mode;
		return v;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				result_ch.ready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 9) == 0) begin
				sink_hold = $urandom_range(1, 15) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		pump_view_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_views.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_views.pop_front();
				check_field("relay_level", result_ch.relay_level, want.relay_level);
				check_field("working", result_ch.working, want.working);
				check_field("run_mode", result_ch.run_mode, want.run_mode);
				check_field("status", result_ch.status, want.status);
				check_field("stopped_event", result_ch.stopped_event, want.stopped_event);
				check_field("shown_time_ms", result_ch.shown_time_ms, want.shown_time_ms);
			end
		end
	end

	task automatic send_beat(logic [2:0] act, logic [TIME_W-1:0] now, logic [OFFS_W-1:0] offs);
		if (sender_idle && $urandom_range(0, 7) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.action         <= act;
		item_ch.now_ms         <= now;
		item_ch.offset_seconds <= offs;
		do @(posedge clk); while (!item_ch.ready);
		pending_views.push_back(next_pump_view(act, now, offs));
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_views.size() != 0);
	endtask

	task automatic set_timer_config(logic [15:0] work, logic [15:0] wait_min,
		logic [15:0] forced, logic [15:0] relay_data);
		logic [CFG_DATA_W-1:0]  vals [4];
		logic [CFG_INDEX_W-1:0] regs [4];
		vals = '{work, wait_min, forced, relay_data};
		regs = '{REG_WORK_SECONDS, REG_WAIT_MINUTES, REG_FORCED_RUN_SECONDS, REG_RELAY_HIGH_LEVEL};
		drain_results();
		foreach (regs[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (regs[i])
				REG_WORK_SECONDS:       cfg_work_s   = vals[i];
				REG_WAIT_MINUTES:       cfg_wait_min = vals[i];
				REG_FORCED_RUN_SECONDS: cfg_forced_s = vals[i];
				REG_RELAY_HIGH_LEVEL:   cfg_relay_hi = vals[i][0];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random_items(int count);
		logic [2:0]        act;
		logic [TIME_W-1:0] now;
		logic [OFFS_W-1:0] offs;
		int                pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) act = ACT_TICK;
			else if (pick < 67) act = ACT_START_NORMAL;
			else if (pick < 71) act = ACT_START_FORCED;
			else if (pick < 76) act = ACT_START_TIMED;
			else if (pick < 82) act = ACT_STOP;
			else if (pick < 91) act = ACT_SET_OFFSET;
			else if (pick < 96) act = ACT_NOP;
			else act = ACT_RESERVED;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: sim_ms += $urandom_range(0, 400);
				10, 11, 12, 13, 14, 15:      sim_ms += $urandom_range(0, 4000);
				16, 17, 18:                  sim_ms += $urandom_range(0, 130000);
				default:                     sim_ms += $urandom;
			endcase
			// occasional out-of-order clock value
			now = ($urandom_range(0, 49) == 0) ? $urandom : sim_ms;
			offs = OFFS_W'($urandom);
			if (act == ACT_SET_OFFSET && $urandom_range(0, 2) != 0)
				offs = 23'($urandom_range(0, 120)) - 23'd60;
			send_beat(act, now, offs);
			if ($urandom_range(0, 149) == 0) drain_results();
		end
	endtask

	task automatic test_directed_actions();
		sender_idle = 1'b1;
		sink_idle   = 1'b1;
		set_timer_config(16'd2, 16'd1, 16'd3, 16'd0);
		send_beat(ACT_TICK, 32'd0, '0);
		send_beat(ACT_TICK, 32'd60000, '0);
		send_beat(ACT_TICK, 32'd61000, '0);
		send_beat(ACT_TICK, 32'd62000, '0);
		// stop while already stopped
		send_beat(ACT_STOP, 32'd62500, '0);
		send_beat(ACT_SET_OFFSET, 32'd63000, 23'h3FFFFF);
		send_beat(ACT_TICK, 32'd63000, '0);
		send_beat(ACT_SET_OFFSET, 32'd64000, 23'h400000);
		send_beat(ACT_TICK, 32'd64000, 23'h7FFFFF);
		send_beat(ACT_START_FORCED, 32'hFFFF_FF00, '0);
		send_beat(ACT_TICK, 32'h0000_0100, '0);
		send_beat(ACT_START_TIMED, 32'd5000, '0);
		send_beat(ACT_TICK, 32'd8000, '0);
		send_beat(ACT_NOP, 32'hFFFF_FFFF, 23'h7FFFFF);
		send_beat(ACT_RESERVED, 32'hFFFF_FFFF, 23'h2AAAAA);
		send_beat(ACT_START_NORMAL, 32'hFFFF_FFFF, 23'h555555);
		// remaining time clamps to zero once the end stamp wraps
		send_beat(ACT_TICK, 32'hFFFF_FFFF, '0);
		send_beat(ACT_STOP, 32'hFFFF_FFFF, '0);
	endtask

	task automatic test_zero_work_time();
		set_timer_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_beat(ACT_TICK, 32'd0, '0);
		send_beat(ACT_START_NORMAL, 32'd100, '0);
		send_beat(ACT_TICK, 32'd100, '0);
		send_beat(ACT_START_FORCED, 32'd200, '0);
		send_beat(ACT_STOP, 32'd300, '0);
	endtask

	task automatic test_auto_cycles();
		sender_idle = 1'b1;
		sink_idle   = 1'b1;
		sim_ms = 32'hFFF0_0000;
		set_timer_config(16'd1, 16'd1, 16'd2, 16'd0);
		run_random_items(BEATS_PER_PHASE);
		sink_idle = 1'b0;
		set_timer_config(16'd3, 16'd2, 16'd0, 16'h0001);
		run_random_items(BEATS_PER_PHASE);
	endtask

	task automatic test_extreme_periods();
		sender_idle = 1'b0;
		sink_idle   = 1'b1;
		set_timer_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random_items(BEATS_PER_PHASE);
	endtask

	task automatic test_manual_only();
		sender_idle = 1'b1;
		sink_idle   = 1'b1;
		set_timer_config(16'd0, 16'd1, 16'd4, 16'd0);
		run_random_items(BEATS_PER_PHASE);
		set_timer_config(16'd2, 16'd0, 16'd1, 16'd1);
		run_random_items(BEATS_PER_PHASE);
	endtask

	task automatic test_back_to_back();
		sender_idle = 1'b0;
		sink_idle   = 1'b0;
		set_timer_config(16'd1, 16'd1, 16'd1, 16'd0);
		run_random_items(BEATS_PER_PHASE);
	endtask

	initial begin
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.action         = ACT_TICK;
		item_ch.now_ms         = '0;
		item_ch.offset_seconds = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = REG_WORK_SECONDS;
		cfg_ch.data            = '0;
		cfg_work_s             = '0;
		cfg_wait_min           = '0;
		cfg_forced_s           = '0;
		cfg_relay_hi           = 1'b0;
		p_running              = 1'b0;
		p_mode                 = MODE_NORMAL;
		p_started_at           = '0;
		p_stopped_at           = '0;
		p_offset_ms            = '0;
		sim_ms                 = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_actions();
		test_zero_work_time();
		test_auto_cycles();
		test_extreme_periods();
		test_manual_only();
		test_back_to_back();

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_views.size() != 0)
			report_mismatch($sformatf("%0d expected beats never arrived", pending_views.size()));
		if (mismatches == 0) begin
			$display("pump_cycle_timer_top verification clean");
		end else begin
			$display("pump_cycle_timer_top verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/pct_pkg.sv
hdl/pct_if.sv
hdl/pct_cfg.sv
hdl/pct_front.sv
hdl/pct_queue.sv
hdl/pct_back.sv
hdl/pump_cycle_timer_top.sv
tb/tb.sv
